FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define HRIC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hric assertion failed");

// Next-cycle implication, disabled while rst is high.
`define HRIC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hric assertion failed");

`endif

FILE: rtl/hric_pkg.sv
`default_nettype none

package hric_pkg;

   typedef enum logic [1:0] {
      MODE_BANDS  = 2'd0,
      MODE_RANGE  = 2'd1,
      MODE_SCALED = 2'd2
   } mode_type;

   localparam logic [1:0] CSR_MODE       = 2'd0;
   localparam logic [1:0] CSR_TARGET     = 2'd1;
   localparam logic [1:0] CSR_RANGE_LOW  = 2'd2;
   localparam logic [1:0] CSR_RANGE_HIGH = 2'd3;

   localparam logic [1:0] RST_MODE       = 2'd0;
   localparam logic [7:0] RST_TARGET     = 8'd120;
   localparam logic [7:0] RST_RANGE_LOW  = 8'd100;
   localparam logic [7:0] RST_RANGE_HIGH = 8'd140;

   localparam logic [7:0] INCLINE_MAX  = 8'd150;
   localparam logic [7:0] INCLINE_STEP = 8'd10;
   localparam logic [7:0] LOSS_TICKS   = 8'd60;
   localparam logic [7:0] COUNT_MAX    = 8'd255;

   localparam logic [7:0] DWELL_SLOW = 8'd30;
   localparam logic [7:0] DWELL_MID  = 8'd15;
   localparam logic [7:0] DWELL_FAST = 8'd10;

   // offsets around the target in mode 0, and the half band of mode 2
   localparam logic [8:0] BAND_DEAD     = 9'd2;
   localparam logic [8:0] BAND_NEAR     = 9'd3;
   localparam logic [8:0] BAND_MID_IN   = 9'd10;
   localparam logic [8:0] BAND_MID_OUT  = 9'd11;
   localparam logic [8:0] BAND_FAR_IN   = 9'd25;
   localparam logic [8:0] BAND_FAR_OUT  = 9'd26;
   localparam logic [8:0] SCALED_HALF   = 9'd3;
   localparam logic [8:0] SCALED_LOW_UP = 9'd4;

   localparam logic [15:0] PCT_SCALE = 16'd100;

   typedef struct packed {
      logic ctrl;   // mode performs control, dwell advances
      logic hold;   // inside the band, clear dwell
      logic up;     // step incline up
      logic down;   // step incline down
   } decision_type;

endpackage

`default_nettype wire

FILE: rtl/heart_rate_incline_controller.sv
// Path: an accepted request word goes through the input register, then the response
//   register, where it is held while rsp_stall holds the response.
// Throughput: one word per cycle unless rsp_stall holds the response; dwell and lost
//   counters update as a word leaves the input register, so the next word sees them at once.
// Reset (synchronous, active high): clears valids and counters, loads register defaults.
`default_nettype none

module heart_rate_incline_controller (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_en,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_heart_rate,
   input  wire logic [7:0] req_current_incline,
   input  wire logic [7:0] req_rate_percent,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_new_incline,
   output logic            rsp_incline_changed,
   output logic            rsp_pulse_lost
);

   logic [1:0]  mode_ff;
   logic [7:0]  target_ff;
   logic [7:0]  range_low_ff;
   logic [7:0]  range_high_ff;

   logic        s1_valid_ff;
   logic [7:0]  s1_heart_rate_ff;
   logic [7:0]  s1_incline_ff;
   logic [15:0] s1_product_ff;
   logic [15:0] s1_product_in;

   logic [7:0]  dwell_ff;
   logic [7:0]  dwell_in;
   logic [7:0]  lost_ff;
   logic [7:0]  lost_in;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_incline_ff;
   logic [7:0]  rsp_incline_in;
   logic        rsp_changed_ff;
   logic        rsp_changed_in;
   logic        rsp_lost_ff;
   logic        rsp_lost_in;

   logic        advance;
   logic        req_take;

   hric_pkg::decision_type decision;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // target only changes while idle (a rule for the user, not enforced here), so the product can be formed on entry
   assign s1_product_in = 16'(req_rate_percent) * 16'(target_ff);

   hric_band u_band (
      .mode           (mode_ff),
      .target_rate    (target_ff),
      .range_low      (range_low_ff),
      .range_high     (range_high_ff),
      .heart_rate     (s1_heart_rate_ff),
      .scaled_product (s1_product_ff),
      .dwell          (dwell_ff),
      .decision       (decision)
   );

   hric_incline u_incline (
      .heart_rate      (s1_heart_rate_ff),
      .current_incline (s1_incline_ff),
      .decision        (decision),
      .dwell           (dwell_ff),
      .lost_count      (lost_ff),
      .new_incline     (rsp_incline_in),
      .incline_changed (rsp_changed_in),
      .pulse_lost      (rsp_lost_in),
      .dwell_next      (dwell_in),
      .lost_next       (lost_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= hric_pkg::RST_MODE;
         target_ff     <= hric_pkg::RST_TARGET;
         range_low_ff  <= hric_pkg::RST_RANGE_LOW;
         range_high_ff <= hric_pkg::RST_RANGE_HIGH;
      end else if (csr_write_en) begin
         case (csr_index)
            hric_pkg::CSR_MODE:       mode_ff       <= csr_wdata[1:0];
            hric_pkg::CSR_TARGET:     target_ff     <= csr_wdata;
            hric_pkg::CSR_RANGE_LOW:  range_low_ff  <= csr_wdata;
            hric_pkg::CSR_RANGE_HIGH: range_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dwell_ff     <= 8'd0;
         lost_ff      <= 8'd0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         // commit counters as the word moves into the response register
         if (s1_valid_ff && advance) begin
            dwell_ff <= dwell_in;
            lost_ff  <= lost_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_heart_rate_ff <= req_heart_rate;
         s1_incline_ff    <= req_current_incline;
         s1_product_ff    <= s1_product_in;
      end
      if (s1_valid_ff && advance) begin
         rsp_incline_ff <= rsp_incline_in;
         rsp_changed_ff <= rsp_changed_in;
         rsp_lost_ff    <= rsp_lost_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_new_incline     = rsp_incline_ff;
   assign rsp_incline_changed = rsp_changed_ff;
   assign rsp_pulse_lost      = rsp_lost_ff;

endmodule

`default_nettype wire

FILE: rtl/hric_band.sv
`default_nettype none

module hric_band (
   input  wire logic [1:0]  mode,
   input  wire logic [7:0]  target_rate,
   input  wire logic [7:0]  range_low,
   input  wire logic [7:0]  range_high,
   input  wire logic [7:0]  heart_rate,
   input  wire logic [15:0] scaled_product,
   input  wire logic [7:0]  dwell,
   output hric_pkg::decision_type decision
);

   logic [8:0]  h9;
   logic [8:0]  t9;
   logic [15:0] low_bound;
   logic [15:0] high_bound;
   logic        dw_slow_eq;
   logic        dw_slow_ge;
   logic        dw_mid_eq;
   logic        dw_mid_ge;
   logic        dw_fast_ge;
   logic        up_near;
   logic        up_mid;
   logic        up_far;
   logic        scaled_below;
   logic        scaled_above;

   assign h9 = {1'b0, heart_rate};
   assign t9 = {1'b0, target_rate};

   assign dw_slow_eq = (dwell == hric_pkg::DWELL_SLOW);
   assign dw_slow_ge = (dwell >= hric_pkg::DWELL_SLOW);
   assign dw_mid_eq  = (dwell == hric_pkg::DWELL_MID);
   assign dw_mid_ge  = (dwell >= hric_pkg::DWELL_MID);
   assign dw_fast_ge = (dwell >= hric_pkg::DWELL_FAST);

   assign up_near = (h9 + hric_pkg::BAND_MID_IN > t9) && (h9 + hric_pkg::BAND_NEAR < t9);
   assign up_mid  = (h9 + hric_pkg::BAND_FAR_IN > t9) && (h9 + hric_pkg::BAND_MID_OUT < t9);
   assign up_far  = (h9 + hric_pkg::BAND_FAR_OUT < t9);

   // scaled band: compare 100*h against target*percent instead of dividing
   assign low_bound  = 16'(h9 + hric_pkg::SCALED_LOW_UP) * hric_pkg::PCT_SCALE;
   assign high_bound = 16'(h9 - hric_pkg::SCALED_HALF) * hric_pkg::PCT_SCALE;
   assign scaled_below = (scaled_product >= low_bound);
   assign scaled_above = (h9 >= hric_pkg::SCALED_HALF) && (high_bound > scaled_product);

   always_comb begin
      decision = '0;
      case (mode)
         hric_pkg::MODE_BANDS: begin
            decision.ctrl = 1'b1;
            decision.hold = (h9 + hric_pkg::BAND_DEAD >= t9) &&
                            (h9 <= t9 + hric_pkg::BAND_DEAD);
            decision.up   = (up_near && dw_slow_eq) || (up_mid && dw_mid_ge) ||
                            (up_far && dw_fast_ge);
            decision.down = !decision.up && (h9 >= t9 + hric_pkg::BAND_NEAR) && dw_mid_ge;
         end
         hric_pkg::MODE_RANGE: begin
            decision.ctrl = 1'b1;
            decision.hold = (heart_rate >= range_low) && (heart_rate <= range_high);
            // inverted range: up has priority over down, so only one fires
            decision.up   = (heart_rate < range_low) && dw_slow_eq;
            decision.down = !decision.up && (heart_rate > range_high) && dw_slow_ge;
         end
         hric_pkg::MODE_SCALED: begin
            decision.ctrl = 1'b1;
            decision.hold = !scaled_below && !scaled_above;
            decision.up   = scaled_below && dw_mid_eq;
            decision.down = scaled_above && dw_mid_ge;
         end
         default: decision = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/hric_incline.sv
`default_nettype none

module hric_incline (
   input  wire logic [7:0]           heart_rate,
   input  wire logic [7:0]           current_incline,
   input  wire hric_pkg::decision_type decision,
   input  wire logic [7:0]           dwell,
   input  wire logic [7:0]           lost_count,
   output logic      [7:0]           new_incline,
   output logic                      incline_changed,
   output logic                      pulse_lost,
   output logic      [7:0]           dwell_next,
   output logic      [7:0]           lost_next
);

   logic [7:0] inc_clamped;
   logic [8:0] inc_raised;
   logic       no_pulse;

   assign no_pulse    = (heart_rate == 8'd0);
   assign inc_clamped = (current_incline > hric_pkg::INCLINE_MAX) ?
                        hric_pkg::INCLINE_MAX : current_incline;
   assign inc_raised  = {1'b0, inc_clamped} + {1'b0, hric_pkg::INCLINE_STEP};

   always_comb begin
      new_incline     = inc_clamped;
      incline_changed = 1'b0;
      pulse_lost      = 1'b0;
      dwell_next      = dwell;
      lost_next       = lost_count;
      if (no_pulse) begin
         if (lost_count >= hric_pkg::LOSS_TICKS) begin
            pulse_lost      = 1'b1;
            new_incline     = 8'd0;
            incline_changed = 1'b1;
         end
         if (lost_count != hric_pkg::COUNT_MAX) begin
            lost_next = lost_count + 8'd1;
         end
      end else begin
         lost_next = 8'd0;
         if (decision.up && inc_clamped < hric_pkg::INCLINE_MAX) begin
            new_incline     = (inc_raised > {1'b0, hric_pkg::INCLINE_MAX}) ?
                              hric_pkg::INCLINE_MAX : inc_raised[7:0];
            incline_changed = 1'b1;
         end else if (decision.down && inc_clamped != 8'd0) begin
            new_incline     = (inc_clamped < hric_pkg::INCLINE_STEP) ?
                              8'd0 : inc_clamped - hric_pkg::INCLINE_STEP;
            incline_changed = 1'b1;
         end
         if (decision.ctrl) begin
            // band hold or a step restarts dwell from zero before the increment
            dwell_next = (decision.hold || decision.up || decision.down) ?
                         8'd1 : dwell + 8'd1;
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/hric_checker.sv
`default_nettype none
`include "assert_macros.svh"

module hric_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_new_incline,
   input wire logic       rsp_incline_changed,
   input wire logic       rsp_pulse_lost
);

   `HRIC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   `HRIC_ASSERT_NOW(a_incline_range, clock, reset, rsp_valid, rsp_new_incline <= 8'd150)
   `HRIC_ASSERT_NOW(a_lost_stops, clock, reset, rsp_valid && rsp_pulse_lost, rsp_incline_changed && rsp_new_incline == 8'd0)
   `HRIC_ASSERT_NEXT(a_latency, clock, reset, (req_valid && !req_stall) ##1 !rsp_stall, rsp_valid)
   `HRIC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_new_incline))

endmodule

bind heart_rate_incline_controller hric_checker u_hric_checker (.*);

`default_nettype wire
